// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the SOF scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JSDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define JSDS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/jsds_pkg.sv
// Package for the JPEG SOF scanner: codes, bundles and marker decode.
`default_nettype none
package jsds_pkg;

  // Parse phases
  localparam logic [2:0] PH_START0 = 3'd0;
  localparam logic [2:0] PH_START1 = 3'd1;
  localparam logic [2:0] PH_START2 = 3'd2;
  localparam logic [2:0] PH_HUNT   = 3'd3;
  localparam logic [2:0] PH_MARK   = 3'd4;
  localparam logic [2:0] PH_LEN_HI = 3'd5;
  localparam logic [2:0] PH_LEN_LO = 3'd6;
  localparam logic [2:0] PH_BODY   = 3'd7;

  // Result status codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_EOI       = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_ENDED     = 3'd4;
  localparam logic [2:0] ST_ABORTED   = 3'd5;

  // Marker bytes
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] MRK_SOI  = 8'hD8;
  localparam logic [7:0] MRK_EOI  = 8'hD9;
  localparam logic [7:0] MRK_RST0 = 8'hD0;

  // Segment offsets of the first body byte and the dimension bytes, and length minimums
  localparam logic [15:0] OFF_FIRST   = 16'd2;
  localparam logic [15:0] OFF_HEIGHT1 = 16'd3;
  localparam logic [15:0] OFF_HEIGHT0 = 16'd4;
  localparam logic [15:0] OFF_WIDTH1  = 16'd5;
  localparam logic [15:0] OFF_WIDTH0  = 16'd6;
  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] LEN_SOF_MIN = 16'd8;

  // One parsed byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       abort;
  } step_t;

  // Result from the parser
  typedef struct packed {
    logic        valid;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  status;
  } res_t;

  // SOF0-3, 5-7, 9-11, 13-15
  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
  endfunction

endpackage
`default_nettype wire

// File: src/jpeg_sof_dimension_scanner.sv
// A result item is registered as the byte that causes it leaves the input register.
// Throughput: one byte per cycle; the input register and result register decouple
// the channels, and only a stalled result with a full input register blocks input.
// Reset (synchronous, rst_n low): parser back to expecting FF D8, both stages empty.
// Top level of the JPEG SOF scanner: input register, parser, result register.
`default_nettype none
`include "assert_macros.svh"
module jpeg_sof_dimension_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        in_abort,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_width,
  output logic [15:0]      out_height,
  output logic [2:0]       out_status
);

  logic            s1_valid_r, s1_valid_nxt;
  jsds_pkg::step_t s1_step_r;
  logic            out_valid_r, out_valid_nxt;
  jsds_pkg::res_t  out_res_r;
  jsds_pkg::res_t  res;
  logic            out_free;
  logic            step_en;
  logic            in_fire;

  // Handshake
  assign out_free     = !out_valid_r || out_ready;
  assign step_en      = s1_valid_r && out_free;
  assign in_ready     = !s1_valid_r || out_free;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !out_free);
  assign out_valid_nxt = step_en ? res.valid : (out_valid_r && !out_ready);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_step_r.data_byte <= in_data_byte;
      s1_step_r.last_byte <= in_last_byte;
      s1_step_r.abort     <= in_abort;
    end
  end

  jsds_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .step    (s1_step_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_width  = out_res_r.width;
  assign out_height = out_res_r.height;
  assign out_status = out_res_r.status;

  // Checks
  `JSDS_ASSERT_IMP(a_zero_dims, out_valid_r && out_status != jsds_pkg::ST_FOUND, out_width == 16'd0 && out_height == 16'd0)
  `JSDS_ASSERT_IMP(a_found_dims, out_valid_r && out_status == jsds_pkg::ST_FOUND, out_width != 16'd0 && out_height != 16'd0)
  `JSDS_ASSERT_IMP(a_block_cause, !in_ready, s1_valid_r && out_valid_r && !out_ready)
  `JSDS_ASSERT_NXT(a_stall_keeps, s1_valid_r && out_valid_r && !out_ready, s1_valid_r)

endmodule
`default_nettype wire

// File: src/jsds_parse.sv
// Parser state and per-byte update for the JPEG SOF scanner.
`default_nettype none
module jsds_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  wire jsds_pkg::step_t step,
  output jsds_pkg::res_t      res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] off_r, off_nxt;
  logic        frame_r, frame_nxt;
  logic [15:0] cap_h_r, cap_h_nxt;
  logic [15:0] cap_w_r, cap_w_nxt;
  logic        given_r, given_nxt;

  // Update the parser for one item
  always_comb begin
    logic        st_v;
    logic [2:0]  st;
    logic [15:0] len_lo;
    logic [15:0] off_inc;
    logic [7:0]  b;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    frame_nxt = frame_r;
    cap_h_nxt = cap_h_r;
    cap_w_nxt = cap_w_r;
    given_nxt = given_r;
    st_v      = 1'b0;
    st        = jsds_pkg::ST_ENDED;
    b         = step.data_byte;
    len_lo    = {len_r[15:8], b};
    off_inc   = off_r + 16'd1;
    res       = '0;

    if (step_en) begin
      if (given_r) begin
        // drop bytes until the last one, then rearm
        if (step.last_byte) begin
          given_nxt = 1'b0;
          phase_nxt = jsds_pkg::PH_START0;
          len_nxt   = '0;
          off_nxt   = '0;
          frame_nxt = 1'b0;
          cap_h_nxt = '0;
          cap_w_nxt = '0;
        end
      end else begin
        if (step.abort) begin
          st_v = 1'b1;
          st   = jsds_pkg::ST_ABORTED;
        end else begin
          unique case (phase_r)
            jsds_pkg::PH_START0: begin
              if (b != jsds_pkg::BYTE_FF || step.last_byte) begin
                st_v = 1'b1;
                st   = jsds_pkg::ST_BAD_START;
              end else begin
                phase_nxt = jsds_pkg::PH_START1;
              end
            end
            jsds_pkg::PH_START1: begin
              if (b != jsds_pkg::MRK_SOI || step.last_byte) begin
                st_v = 1'b1;
                st   = jsds_pkg::ST_BAD_START;
              end else begin
                phase_nxt = jsds_pkg::PH_START2;
              end
            end
            jsds_pkg::PH_START2: begin
              if (step.last_byte) begin
                st_v = 1'b1;
                st   = jsds_pkg::ST_BAD_START;
              end else begin
                phase_nxt = (b == jsds_pkg::BYTE_FF) ? jsds_pkg::PH_MARK : jsds_pkg::PH_HUNT;
              end
            end
            jsds_pkg::PH_MARK: begin
              if (b == jsds_pkg::BYTE_FF) begin
                // fill byte: hold
              end else if (b == jsds_pkg::BYTE_00 ||
                           (b >= jsds_pkg::MRK_RST0 && b <= jsds_pkg::MRK_SOI)) begin
                phase_nxt = jsds_pkg::PH_HUNT;
              end else if (b == jsds_pkg::MRK_EOI) begin
                st_v = 1'b1;
                st   = jsds_pkg::ST_EOI;
              end else begin
                frame_nxt = jsds_pkg::is_frame_marker(b);
                cap_h_nxt = '0;
                cap_w_nxt = '0;
                phase_nxt = jsds_pkg::PH_LEN_HI;
              end
            end
            jsds_pkg::PH_LEN_HI: begin
              len_nxt   = {b, 8'h00};
              phase_nxt = jsds_pkg::PH_LEN_LO;
            end
            jsds_pkg::PH_LEN_LO: begin
              len_nxt = len_lo;
              if (len_lo < jsds_pkg::LEN_MIN) begin
                st_v = 1'b1;
                st   = jsds_pkg::ST_BAD_LEN;
              end else begin
                off_nxt = jsds_pkg::OFF_FIRST;
                // an empty segment can never be a valid frame header
                phase_nxt = (len_lo == jsds_pkg::LEN_MIN) ? jsds_pkg::PH_HUNT
                                                           : jsds_pkg::PH_BODY;
              end
            end
            jsds_pkg::PH_BODY: begin
              case (off_r)
                jsds_pkg::OFF_HEIGHT1: cap_h_nxt = {b, cap_h_r[7:0]};
                jsds_pkg::OFF_HEIGHT0: cap_h_nxt = {cap_h_r[15:8], b};
                jsds_pkg::OFF_WIDTH1:  cap_w_nxt = {b, cap_w_r[7:0]};
                jsds_pkg::OFF_WIDTH0:  cap_w_nxt = {cap_w_r[15:8], b};
                default: ;
              endcase
              off_nxt = off_inc;
              if (off_inc >= len_r) begin
                if (frame_r && len_r >= jsds_pkg::LEN_SOF_MIN &&
                    cap_w_nxt != 16'd0 && cap_h_nxt != 16'd0) begin
                  st_v = 1'b1;
                  st   = jsds_pkg::ST_FOUND;
                end else begin
                  phase_nxt = jsds_pkg::PH_HUNT;
                end
              end
            end
            default: begin
              // hunt for the next marker prefix
              phase_nxt = (b == jsds_pkg::BYTE_FF) ? jsds_pkg::PH_MARK : jsds_pkg::PH_HUNT;
            end
          endcase
        end

        // end of data before any verdict
        if (!st_v && step.last_byte) begin
          st_v = 1'b1;
          st   = jsds_pkg::ST_ENDED;
        end

        if (st_v) begin
          res.valid  = 1'b1;
          res.status = st;
          res.width  = (st == jsds_pkg::ST_FOUND) ? cap_w_nxt : 16'd0;
          res.height = (st == jsds_pkg::ST_FOUND) ? cap_h_nxt : 16'd0;
          given_nxt  = 1'b1;
          if (step.last_byte) begin
            given_nxt = 1'b0;
            phase_nxt = jsds_pkg::PH_START0;
            len_nxt   = '0;
            off_nxt   = '0;
            frame_nxt = 1'b0;
            cap_h_nxt = '0;
            cap_w_nxt = '0;
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsds_pkg::PH_START0;
      len_r   <= '0;
      off_r   <= '0;
      frame_r <= 1'b0;
      cap_h_r <= '0;
      cap_w_r <= '0;
      given_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      frame_r <= frame_nxt;
      cap_h_r <= cap_h_nxt;
      cap_w_r <= cap_w_nxt;
      given_r <= given_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sim/jpeg_sof_dimension_scanner_tb.sv
// Self-checking testbench for the JPEG SOF dimension scanner.
`default_nettype none
module jpeg_sof_dimension_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1200;
  localparam int IDLE_PCT = 23;

  // Marker bytes used to build files
  localparam logic [7:0] MRK_SOF0  = 8'hC0;
  localparam logic [7:0] MRK_SOF15 = 8'hCF;
  localparam logic [7:0] MRK_DHT   = 8'hC4;
  localparam logic [7:0] MRK_APP0  = 8'hE0;
  localparam logic [7:0] MRK_APP15 = 8'hEF;
  localparam logic [7:0] MRK_RST7  = jsds_pkg::MRK_RST0 + 8'd7;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  status;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        in_abort = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic [2:0]  out_status;

  jpeg_sof_dimension_scanner u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_abort     (in_abort),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_width    (out_width),
    .out_height   (out_height),
    .out_status   (out_status)
  );

  always #1 clk = ~clk;

  // Scanner state mirrored by the predictor
  logic [2:0]  ph = jsds_pkg::PH_START0;
  logic [15:0] seg_len = '0;
  logic [15:0] seg_off = '0;
  logic        in_frame_seg = 1'b0;
  logic [15:0] cap_height = '0;
  logic [15:0] cap_width = '0;
  logic        verdict_given = 1'b0;

  scan_result_t pending_verdicts[$];
  scan_result_t oldest;
  logic [7:0]   file_bytes[$];

  bit no_stall = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int files_sent = 0;
  int bytes_sent = 0;
  int bytes_parsed = 0;
  int status_seen[8];

  // Start-of-frame markers: C0-C3, C5-C7, C9-CB, CD-CF
  function automatic logic is_sof(input logic [7:0] m);
    return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
           (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
  endfunction

  task automatic clear_scan();
    ph = jsds_pkg::PH_START0;
    seg_len = '0;
    seg_off = '0;
    in_frame_seg = 1'b0;
    cap_height = '0;
    cap_width = '0;
    verdict_given = 1'b0;
  endtask

  // Segment fully read: found, or back to hunting
  function automatic logic frame_complete();
    if (in_frame_seg && seg_len >= jsds_pkg::LEN_SOF_MIN &&
        cap_width != 16'd0 && cap_height != 16'd0)
      return 1'b1;
    ph = jsds_pkg::PH_HUNT;
    return 1'b0;
  endfunction

  // Advance the mirrored scanner by one accepted item
  task automatic predict_scan_step(input logic [7:0] b, input logic last, input logic ab);
    logic [2:0]   st;
    logic         have;
    scan_result_t res;
    have = 1'b0;
    st = jsds_pkg::ST_ENDED;
    if (verdict_given) begin
      if (last) clear_scan();
      return;
    end
    bytes_parsed++;
    if (ab) begin
      have = 1'b1;
      st = jsds_pkg::ST_ABORTED;
    end else begin
      case (ph)
        jsds_pkg::PH_START0: begin
          if (b != jsds_pkg::BYTE_FF || last) begin have = 1'b1; st = jsds_pkg::ST_BAD_START; end
          else ph = jsds_pkg::PH_START1;
        end
        jsds_pkg::PH_START1: begin
          if (b != jsds_pkg::MRK_SOI || last) begin have = 1'b1; st = jsds_pkg::ST_BAD_START; end
          else ph = jsds_pkg::PH_START2;
        end
        jsds_pkg::PH_START2: begin
          if (last) begin have = 1'b1; st = jsds_pkg::ST_BAD_START; end
          else ph = (b == jsds_pkg::BYTE_FF) ? jsds_pkg::PH_MARK : jsds_pkg::PH_HUNT;
        end
        jsds_pkg::PH_MARK: begin
          if (b == jsds_pkg::BYTE_FF) begin
            // fill byte, stay
          end else if (b == jsds_pkg::BYTE_00 || (b >= jsds_pkg::MRK_RST0 && b <= MRK_RST7) ||
                       b == jsds_pkg::MRK_SOI) begin
            ph = jsds_pkg::PH_HUNT;
          end else if (b == jsds_pkg::MRK_EOI) begin
            have = 1'b1;
            st = jsds_pkg::ST_EOI;
          end else begin
            in_frame_seg = is_sof(b);
            cap_height = '0;
            cap_width = '0;
            ph = jsds_pkg::PH_LEN_HI;
          end
        end
        jsds_pkg::PH_LEN_HI: begin
          seg_len = {b, 8'h00};
          ph = jsds_pkg::PH_LEN_LO;
        end
        jsds_pkg::PH_LEN_LO: begin
          seg_len = {seg_len[15:8], b};
          if (seg_len < jsds_pkg::LEN_MIN) begin
            have = 1'b1;
            st = jsds_pkg::ST_BAD_LEN;
          end else begin
            seg_off = jsds_pkg::OFF_FIRST;
            if (seg_len == jsds_pkg::LEN_MIN) begin
              if (frame_complete()) begin have = 1'b1; st = jsds_pkg::ST_FOUND; end
            end else ph = jsds_pkg::PH_BODY;
          end
        end
        jsds_pkg::PH_BODY: begin
          case (seg_off)
            jsds_pkg::OFF_HEIGHT1: cap_height[15:8] = b;
            jsds_pkg::OFF_HEIGHT0: cap_height[7:0] = b;
            jsds_pkg::OFF_WIDTH1:  cap_width[15:8] = b;
            jsds_pkg::OFF_WIDTH0:  cap_width[7:0] = b;
            default: ;
          endcase
          seg_off = seg_off + 16'd1;
          if (seg_off >= seg_len && frame_complete()) begin
            have = 1'b1;
            st = jsds_pkg::ST_FOUND;
          end
        end
        default: ph = (b == jsds_pkg::BYTE_FF) ? jsds_pkg::PH_MARK : jsds_pkg::PH_HUNT;
      endcase
      if (!have && last) begin
        have = 1'b1;
        st = jsds_pkg::ST_ENDED;
      end
    end
    if (have) begin
      res.width  = (st == jsds_pkg::ST_FOUND) ? cap_width : 16'd0;
      res.height = (st == jsds_pkg::ST_FOUND) ? cap_height : 16'd0;
      res.status = st;
      pending_verdicts.push_back(res);
      verdict_given = 1'b1;
      if (last) clear_scan();
    end
  endtask

  // Offer one item, hold it until accepted, then predict
  task automatic send_byte(input logic [7:0] b, input logic last, input logic ab);
    while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    in_abort     <= ab;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    predict_scan_step(b, last, ab);
  endtask

  task automatic send_file(input int abort_at);
    int i;
    for (i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1, i == abort_at);
    files_sent++;
  endtask

  function automatic logic [15:0] pick_dimension();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd1;
    if (r == 2) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Build a random file, mostly well formed, some broken or plain noise
  task automatic build_random_file(output int abort_at);
    int k;
    int i;
    int nseg;
    int r;
    int len;
    int cut;
    logic [7:0]  mk;
    logic [15:0] h;
    logic [15:0] w;
    logic open_seg;
    file_bytes.delete();
    open_seg = 1'b0;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(8, 1)) file_bytes.push_back(8'($urandom_range(255)));
    end else begin
      file_bytes.push_back(jsds_pkg::BYTE_FF);
      file_bytes.push_back(jsds_pkg::MRK_SOI);
      if ($urandom_range(99) < 5) file_bytes[$urandom_range(1)] = 8'($urandom_range(255));
      nseg = $urandom_range(4);
      for (k = 0; k < nseg && !open_seg; k++) begin
        // scan data between markers, with stuffed FF 00 pairs
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(4) == 0) begin
              file_bytes.push_back(jsds_pkg::BYTE_FF);
              file_bytes.push_back(jsds_pkg::BYTE_00);
            end else file_bytes.push_back(8'($urandom_range(255)));
          end
        end
        repeat ($urandom_range(2)) file_bytes.push_back(jsds_pkg::BYTE_FF);
        file_bytes.push_back(jsds_pkg::BYTE_FF);
        r = $urandom_range(99);
        if (r < 40)      mk = 8'($urandom_range(MRK_SOF15, MRK_SOF0));
        else if (r < 60) mk = 8'($urandom_range(MRK_APP15, MRK_APP0));
        else if (r < 70) mk = MRK_DHT;
        else if (r < 80) mk = 8'($urandom_range(255));
        else if (r < 90) mk = ($urandom_range(3) == 0) ? jsds_pkg::BYTE_00 :
                              8'($urandom_range(jsds_pkg::MRK_SOI, jsds_pkg::MRK_RST0));
        else if (r < 95) mk = jsds_pkg::MRK_EOI;
        else mk = MRK_SOF0;
        file_bytes.push_back(mk);
        if (mk == jsds_pkg::BYTE_00 || (mk >= jsds_pkg::MRK_RST0 && mk <= jsds_pkg::MRK_EOI))
          continue;
        // segment length: mostly sane, sometimes bad or oversized
        r = $urandom_range(99);
        if (r < 8)       len = $urandom_range(1);
        else if (r < 13) len = $urandom_range(16'hFFFF, 256);
        else if (is_sof(mk) && r < 80) len = $urandom_range(14, 8);
        else             len = $urandom_range(10, 2);
        file_bytes.push_back(8'(len >> 8));
        file_bytes.push_back(8'(len));
        if (len < 2) continue;
        if (len > 255) begin
          open_seg = 1'b1;
          len = $urandom_range(9, 2);
        end
        h = pick_dimension();
        w = pick_dimension();
        for (i = 2; i < len; i++) begin
          case (i)
            3: file_bytes.push_back(h[15:8]);
            4: file_bytes.push_back(h[7:0]);
            5: file_bytes.push_back(w[15:8]);
            6: file_bytes.push_back(w[7:0]);
            default: file_bytes.push_back(8'($urandom_range(255)));
          endcase
        end
      end
      // trailer: EOI, junk, or nothing
      r = $urandom_range(99);
      if (!open_seg && r < 40) begin
        file_bytes.push_back(jsds_pkg::BYTE_FF);
        file_bytes.push_back(jsds_pkg::MRK_EOI);
      end else if (!open_seg && r < 70) begin
        repeat ($urandom_range(4, 1)) file_bytes.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(file_bytes.size(), 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end
    abort_at = ($urandom_range(99) < 5) ? $urandom_range(file_bytes.size() - 1) : -1;
  endtask

  // Directed: wrong first byte, and starts that are cut short
  task automatic test_start_checks();
    file_bytes = '{8'hAB};
    send_file(-1);
    file_bytes = '{jsds_pkg::BYTE_FF, jsds_pkg::MRK_SOI};
    send_file(-1);
    file_bytes = '{jsds_pkg::BYTE_FF, jsds_pkg::MRK_SOI, jsds_pkg::BYTE_FF};
    send_file(-1);
  endtask

  // Directed: abort on a start byte, and abort ignored after a verdict
  task automatic test_abort();
    file_bytes = '{jsds_pkg::BYTE_FF, jsds_pkg::MRK_SOI};
    send_file(1);
    file_bytes = '{8'hAB, jsds_pkg::BYTE_FF, 8'hCD};
    send_file(1);
  endtask

  // Directed: minimal SOF0 segment with all-ones dimensions, ending on its last byte
  task automatic test_found_extremes();
    file_bytes = '{jsds_pkg::BYTE_FF, jsds_pkg::MRK_SOI, jsds_pkg::BYTE_FF, MRK_SOF0,
                   8'h00, 8'h08, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03};
    send_file(-1);
  endtask

  // Directed: scan data, fill bytes and restart marker, then EOI on the last byte
  task automatic test_marker_skipping();
    file_bytes = '{jsds_pkg::BYTE_FF, jsds_pkg::MRK_SOI, jsds_pkg::BYTE_00,
                   jsds_pkg::BYTE_FF, jsds_pkg::BYTE_FF, jsds_pkg::MRK_RST0,
                   jsds_pkg::BYTE_FF, jsds_pkg::MRK_EOI};
    send_file(-1);
  endtask

  // Directed: length field of one on the last byte
  task automatic test_bad_length();
    file_bytes = '{jsds_pkg::BYTE_FF, jsds_pkg::MRK_SOI, jsds_pkg::BYTE_FF, MRK_APP0,
                   jsds_pkg::BYTE_00, 8'h01};
    send_file(-1);
  endtask

  // Random files until enough bytes were sent; one stretch runs with no stalls
  task automatic test_random_files();
    int abort_at;
    while (bytes_sent < ITEM_TARGET) begin
      no_stall = (bytes_sent >= 500 && bytes_sent < 700);
      build_random_file(abort_at);
      send_file(abort_at);
    end
    no_stall = 1'b0;
  endtask

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted result with the oldest prediction
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no prediction waiting: width %0d height %0d status %0d",
               out_width, out_height, out_status);
        mismatches++;
      end else begin
        oldest = pending_verdicts.pop_front();
        status_seen[oldest.status]++;
        if (out_width !== oldest.width) begin
          $error("width: expected %0d, got %0d", oldest.width, out_width);
          mismatches++;
        end
        if (out_height !== oldest.height) begin
          $error("height: expected %0d, got %0d", oldest.height, out_height);
          mismatches++;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_checks();
    test_abort();
    test_found_extremes();
    test_marker_skipping();
    test_bad_length();
    test_random_files();
    in_valid <= 1'b0;
    // drain the result channel, then allow for pipeline latency
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d predicted results never arrived", pending_verdicts.size());
      mismatches++;
    end
    $display("Scanned %0d files (%0d bytes, %0d parsed) in %0d cycles",
             files_sent, bytes_sent, bytes_parsed, cycles);
    $display("Verdicts: found %0d, bad start %0d, EOI %0d, bad length %0d, ended %0d, aborted %0d",
             status_seen[jsds_pkg::ST_FOUND], status_seen[jsds_pkg::ST_BAD_START],
             status_seen[jsds_pkg::ST_EOI], status_seen[jsds_pkg::ST_BAD_LEN],
             status_seen[jsds_pkg::ST_ENDED], status_seen[jsds_pkg::ST_ABORTED]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+src
src/jsds_pkg.sv
src/jsds_parse.sv
src/jpeg_sof_dimension_scanner.sv
sim/jpeg_sof_dimension_scanner_tb.sv
